// ===== rtl/cleb_pkg.sv =====
// Package for the gap-buffer line editor: sizes, count constants and the
// command/status structs that join the controller and the datapath.
// No dependencies.
package cleb_pkg;

    // Line storage depth and the widths that follow from it
    localparam int LINE_DEPTH = 1024;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int CNT_W      = ADDR_W + 1;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LINE_DEPTH);

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // latch the request and launch the buffer read
        logic commit;   // apply the edit and load the result register
    } cleb_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free; // result register can take a new result this cycle
    } cleb_stat_t;

endpackage

// ===== rtl/cursor_line_editor_buffer.sv =====
// Top level of the gap-buffer line editor: controller plus datapath.
// Depends on cleb_pkg, cleb_ctrl, cleb_dp (and cleb_ram through cleb_dp).
//
//   channel   handshake              payload
//   input     in_valid / in_stall    kind, key_byte, read_index
//   output    out_valid / out_stall  read_char, line_length, cursor_pos, status
//
// Each request has an accept step, which issues the one buffer read, and a
// commit step, which writes the moved or inserted byte and loads the result.
// The single-port character RAM sets these steps (one read, one write).
// A stalled result holds the commit cycle, so at most one result waits.
// Reset clears the counts and the control state; the RAM needs no clearing.
module cursor_line_editor_buffer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  key_byte,
    input  logic [9:0]  read_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_char,
    output logic [10:0] line_length,
    output logic [10:0] cursor_pos,
    output logic [1:0]  status
);

    cleb_pkg::cleb_cmd_t  cmd;
    cleb_pkg::cleb_stat_t stat;

    cleb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    cleb_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .kind        (kind),
        .key_byte    (key_byte),
        .read_index  (read_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_char   (read_char),
        .line_length (line_length),
        .cursor_pos  (cursor_pos),
        .status      (status)
    );

endmodule

// ===== rtl/cleb_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module cleb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on we, register read data on re
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// ===== rtl/cleb_ctrl.sv =====
// Controller for the line editor: request acceptance and commit sequencing.
// Depends on cleb_pkg.
module cleb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  cleb_pkg::cleb_stat_t stat,
    output cleb_pkg::cleb_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_FINISH = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != ST_IDLE);

    // Sequence: accept and read, then commit once the result slot is free
    always_comb
    begin
        state_next = state_reg;
        cmd.accept = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/cleb_dp.sv =====
// Datapath for the line editor: gap counts, address generation, character
// RAM and the result register. Depends on cleb_pkg and cleb_ram.
module cleb_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cleb_pkg::cleb_cmd_t          cmd,
    output cleb_pkg::cleb_stat_t         stat,
    input  logic [1:0]                  kind,
    input  logic [7:0]                  key_byte,
    input  logic [9:0]                  read_index,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  read_char,
    output logic [10:0]                 line_length,
    output logic [10:0]                 cursor_pos,
    output logic [1:0]                  status
);

    localparam int ADDR_W = cleb_pkg::ADDR_W;
    localparam int CNT_W  = cleb_pkg::CNT_W;

    localparam logic [1:0] KIND_KEY   = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [7:0] KEY_LEFT  = 8'h3C;
    localparam logic [7:0] KEY_RIGHT = 8'h3E;
    localparam logic [7:0] KEY_BACK  = 8'h2D;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_OOR  = 2'd2;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_MOVE_L,
        OP_MOVE_R,
        OP_BACK,
        OP_INSERT,
        OP_FULL,
        OP_READ,
        OP_READ_BAD,
        OP_CLEAR
    } op_t;

    logic [CNT_W-1:0]  left_reg;
    logic [CNT_W-1:0]  right_reg;
    logic [CNT_W-1:0]  left_next;
    logic [CNT_W-1:0]  right_next;
    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  idx_ext;
    logic [CNT_W-1:0]  hi_addr_w;

    op_t               op_reg;
    op_t               op_d;
    logic [ADDR_W-1:0] dst_reg;
    logic [ADDR_W-1:0] dst_d;
    logic [ADDR_W-1:0] src_d;
    logic [7:0]        key_reg;

    logic [ADDR_W-1:0] ram_addr;
    logic              ram_we;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    logic              out_valid_reg;
    logic [7:0]        char_reg;
    logic [CNT_W-1:0]  len_reg;
    logic [CNT_W-1:0]  cur_reg;
    logic [1:0]        status_reg;
    logic [7:0]        char_d;
    logic [1:0]        status_d;

    assign total     = left_reg + right_reg;
    assign idx_ext   = {1'b0, read_index};
    // Position in the right part for a read past the cursor
    assign hi_addr_w = cleb_pkg::DEPTH_CNT - right_reg + (idx_ext - left_reg);

    // Decode the incoming request against the current counts
    always_comb
    begin
        op_d  = OP_NOP;
        src_d = '0;
        dst_d = '0;
        unique case (kind)
            KIND_KEY:
            begin
                unique case (key_byte)
                    KEY_LEFT:
                    begin
                        if (left_reg != '0)
                        begin
                            op_d  = OP_MOVE_L;
                            src_d = ADDR_W'(left_reg - 1'b1);
                            dst_d = ADDR_W'(cleb_pkg::DEPTH_CNT - right_reg - 1'b1);
                        end
                    end
                    KEY_RIGHT:
                    begin
                        if (right_reg != '0)
                        begin
                            op_d  = OP_MOVE_R;
                            src_d = ADDR_W'(cleb_pkg::DEPTH_CNT - right_reg);
                            dst_d = ADDR_W'(left_reg);
                        end
                    end
                    KEY_BACK:
                    begin
                        if (left_reg != '0)
                        begin
                            op_d = OP_BACK;
                        end
                    end
                    default:
                    begin
                        if (total == cleb_pkg::DEPTH_CNT)
                        begin
                            op_d = OP_FULL;
                        end
                        else
                        begin
                            op_d  = OP_INSERT;
                            dst_d = ADDR_W'(left_reg);
                        end
                    end
                endcase
            end
            KIND_READ:
            begin
                if (idx_ext < left_reg)
                begin
                    op_d  = OP_READ;
                    src_d = read_index;
                end
                else if (idx_ext < total)
                begin
                    op_d  = OP_READ;
                    src_d = hi_addr_w[ADDR_W-1:0];
                end
                else
                begin
                    op_d = OP_READ_BAD;
                end
            end
            KIND_CLEAR:
            begin
                op_d = OP_CLEAR;
            end
            default:
            begin
                op_d = OP_NOP;
            end
        endcase
    end

    // Hold the decoded request until commit
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= op_d;
            dst_reg <= dst_d;
            key_reg <= key_byte;
        end
    end

    // Read at accept, write across the gap or insert at commit
    assign ram_addr  = cmd.accept ? src_d : dst_reg;
    assign ram_we    = cmd.commit &&
                       (op_reg == OP_MOVE_L || op_reg == OP_MOVE_R || op_reg == OP_INSERT);
    assign ram_wdata = (op_reg == OP_INSERT) ? key_reg : ram_rdata;

    cleb_ram #(
        .WIDTH (8),
        .DEPTH (cleb_pkg::LINE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (cmd.accept),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Apply the edit to the counts and form the result
    always_comb
    begin
        left_next  = left_reg;
        right_next = right_reg;
        char_d     = '0;
        status_d   = STAT_OK;
        case (op_reg)
            OP_MOVE_L:
            begin
                left_next  = left_reg - 1'b1;
                right_next = right_reg + 1'b1;
            end
            OP_MOVE_R:
            begin
                left_next  = left_reg + 1'b1;
                right_next = right_reg - 1'b1;
            end
            OP_BACK:
            begin
                left_next = left_reg - 1'b1;
            end
            OP_INSERT:
            begin
                left_next = left_reg + 1'b1;
            end
            OP_FULL:
            begin
                status_d = STAT_FULL;
            end
            OP_READ:
            begin
                char_d = ram_rdata;
            end
            OP_READ_BAD:
            begin
                status_d = STAT_OOR;
            end
            OP_CLEAR:
            begin
                left_next  = '0;
                right_next = '0;
            end
            default:
            begin
                left_next = left_reg;
            end
        endcase
    end

    // Advance counts and the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            right_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                left_reg      <= left_next;
                right_reg     <= right_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            char_reg   <= char_d;
            len_reg    <= left_next + right_next;
            cur_reg    <= left_next;
            status_reg <= status_d;
        end
    end

    assign stat.out_free = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign read_char   = char_reg;
    assign line_length = len_reg;
    assign cursor_pos  = cur_reg;
    assign status      = status_reg;

endmodule

// ===== bench/line_check_pkg.sv =====
// Request and status codes plus the line scoreboard for the line editor bench.
// Depends on cleb_pkg for the line depth.
package line_check_pkg;

    // Request kinds
    localparam logic [1:0] KIND_KEY   = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    // Keystroke bytes with an editing meaning
    localparam logic [7:0] KEY_LEFT  = 8'h3C;
    localparam logic [7:0] KEY_RIGHT = 8'h3E;
    localparam logic [7:0] KEY_BACK  = 8'h2D;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [7:0]  read_char;
        logic [10:0] line_length;
        logic [10:0] cursor_pos;
        logic [1:0]  status;
    } line_report_t;

    class line_scoreboard;

        logic [7:0]   text[$];     // edited line, leftmost character first
        int           cursor;      // characters left of the cursor
        line_report_t reports[$];  // expected reports, oldest first
        int           fails;

        function new();
            cursor = 0;
            fails  = 0;
        endfunction

        function int line_len();
            return text.size();
        endfunction

        function int outstanding();
            return reports.size();
        endfunction

        // Apply one accepted request to the line and queue its report
        function void note_request(logic [1:0] k, logic [7:0] b, logic [9:0] idx);
            line_report_t r;
            r = '0;
            r.status = ST_OK;
            case (k)
                KIND_KEY:
                begin
                    if (b == KEY_LEFT)
                    begin
                        if (cursor > 0)
                            cursor--;
                    end
                    else if (b == KEY_RIGHT)
                    begin
                        if (cursor < text.size())
                            cursor++;
                    end
                    else if (b == KEY_BACK)
                    begin
                        if (cursor > 0)
                        begin
                            text.delete(cursor - 1);
                            cursor--;
                        end
                    end
                    else if (text.size() >= cleb_pkg::LINE_DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        text.insert(cursor, b);
                        cursor++;
                    end
                end
                KIND_READ:
                begin
                    if (int'(idx) < text.size())
                        r.read_char = text[idx];
                    else
                        r.status = ST_RANGE;
                end
                KIND_CLEAR:
                begin
                    text.delete();
                    cursor = 0;
                end
                default:
                    ;
            endcase
            r.line_length = 11'(text.size());
            r.cursor_pos  = 11'(cursor);
            reports.push_back(r);
        endfunction

        function void flag(string what, logic [10:0] want, logic [10:0] got);
            fails++;
            if (fails <= 10)
                $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
        endfunction

        // Compare one delivered result with the oldest expected report
        function void check_result(line_report_t got);
            line_report_t want;
            if (reports.size() == 0)
            begin
                flag("result with no request outstanding", 0, 0);
                return;
            end
            want = reports.pop_front();
            if (got.read_char !== want.read_char)
                flag("read_char", want.read_char, got.read_char);
            if (got.line_length !== want.line_length)
                flag("line_length", want.line_length, got.line_length);
            if (got.cursor_pos !== want.cursor_pos)
                flag("cursor_pos", want.cursor_pos, got.cursor_pos);
            if (got.status !== want.status)
                flag("status", want.status, got.status);
        endfunction

        // Count any report that never arrived
        function void close_out();
            if (reports.size() != 0)
                flag("reports never delivered", 0, 11'(reports.size()));
        endfunction

    endclass

endpackage

// ===== bench/cursor_line_editor_buffer_tb.sv =====
// Self-checking bench for the gap-buffer line editor: directed and random
// keystroke, read and clear requests under random idling and back-pressure.
// Depends on cleb_pkg, line_check_pkg and the cursor_line_editor_buffer RTL.
module cursor_line_editor_buffer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [1:0]  kind       = line_check_pkg::KIND_KEY;
    logic [7:0]  key_byte   = 8'h00;
    logic [9:0]  read_index = 10'd0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [7:0]  read_char;
    logic [10:0] line_length;
    logic [10:0] cursor_pos;
    logic [1:0]  status;

    bit sender_idle_on   = 1'b1;
    bit receiver_idle_on = 1'b1;
    bit long_hold_req    = 1'b0;
    int hold_left        = 0;

    line_check_pkg::line_scoreboard sb;

    cursor_line_editor_buffer DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .key_byte    (key_byte),
        .read_index  (read_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_char   (read_char),
        .line_length (line_length),
        .cursor_pos  (cursor_pos),
        .status      (status)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Offer one request at a falling edge and hold it until accepted
    task automatic send_request(input logic [1:0] k, input logic [7:0] b,
                                input logic [9:0] idx);
        int gap;
        gap = 0;
        if (sender_idle_on && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        kind       <= k;
        key_byte   <= b;
        read_index <= idx;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(k, b, idx);
        @(negedge clk);
    endtask

    task automatic send_key(input logic [7:0] b);
        send_request(line_check_pkg::KIND_KEY, b, 10'($urandom_range(0, 1023)));
    endtask

    task automatic send_read(input logic [9:0] idx);
        send_request(line_check_pkg::KIND_READ, 8'($urandom_range(0, 255)), idx);
    endtask

    task automatic send_clear();
        send_request(line_check_pkg::KIND_CLEAR, 8'($urandom_range(0, 255)),
                     10'($urandom_range(0, 1023)));
    endtask

    // Pick mostly positions inside the line, sometimes anywhere
    function automatic logic [9:0] pick_index();
        int len;
        len = sb.line_len();
        if (len > 0 && $urandom_range(0, 3) != 0)
            return 10'($urandom_range(0, len - 1));
        return 10'($urandom_range(0, 1023));
    endfunction

    // Hold off the sender until every report is back
    task automatic drain_pause();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    // Mixed editing on short lines, with reads, clears and spare kinds
    task automatic random_mixed(input int count);
        int r;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                send_key(8'($urandom_range(0, 255)));
            else if (r < 52)
                send_key(line_check_pkg::KEY_LEFT);
            else if (r < 64)
                send_key(line_check_pkg::KEY_RIGHT);
            else if (r < 74)
                send_key(line_check_pkg::KEY_BACK);
            else if (r < 92)
                send_read(pick_index());
            else if (r < 96)
                send_clear();
            else
                send_request(line_check_pkg::KIND_SPARE, 8'($urandom_range(0, 255)),
                             10'($urandom_range(0, 1023)));
        end
    endtask

    // Receiver: random stall bursts, one long hold on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = 80;
                out_stall <= 1'b1;
            end
            else if (receiver_idle_on && $urandom_range(0, 5) == 0)
            begin
                hold_left = $urandom_range(1, 6) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Check every delivered result
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(line_check_pkg::line_report_t'(
                {read_char, line_length, cursor_pos, status}));
    end

    // Stop a hung run
    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int r;
        sb = new();

        // Reset
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty line, edges of the cursor, extreme bytes and indexes
        send_request(line_check_pkg::KIND_CLEAR, 8'hFF, 10'h3FF);
        send_read(10'd0);
        send_key(line_check_pkg::KEY_LEFT);
        send_key(line_check_pkg::KEY_BACK);
        send_key(line_check_pkg::KEY_RIGHT);
        send_key(8'h00);
        send_key(8'hFF);
        send_key(8'h41);
        send_key(line_check_pkg::KEY_LEFT);
        send_key(line_check_pkg::KEY_LEFT);
        send_key(8'h7F);
        send_key(line_check_pkg::KEY_RIGHT);
        send_key(line_check_pkg::KEY_BACK);
        send_read(10'd0);
        send_read(10'd1);
        send_read(10'd2);
        send_read(10'h3FF);
        send_request(line_check_pkg::KIND_SPARE, 8'hFF, 10'h3FF);
        send_key(line_check_pkg::KEY_RIGHT);
        send_key(line_check_pkg::KEY_RIGHT);
        send_read(10'd1);
        send_request(line_check_pkg::KIND_CLEAR, 8'h00, 10'd0);
        send_read(10'd0);

        // Random editing, starting with a long receiver hold
        long_hold_req = 1'b1;
        random_mixed(25);
        drain_pause();

        // Fill the line to the buffer depth with random content
        send_clear();
        while (sb.line_len() < cleb_pkg::LINE_DEPTH)
        begin
            r = $urandom_range(0, 99);
            if (r < 98)
                send_key(8'($urandom_range(0, 255)));
            else if (r < 99)
                send_key(($urandom_range(0, 1) == 0) ? line_check_pkg::KEY_LEFT
                                                     : line_check_pkg::KEY_RIGHT);
            else
                send_read(pick_index());
        end

        // Edit at full depth: dropped inserts, moves, reads, delete and refill
        send_read(10'd0);
        send_read(10'h3FF);
        repeat (12)
        begin
            r = $urandom_range(0, 5);
            case (r)
                0: send_key(8'($urandom_range(0, 255)));
                1: send_key(line_check_pkg::KEY_LEFT);
                2: send_key(line_check_pkg::KEY_RIGHT);
                3: send_read(10'($urandom_range(0, 1023)));
                default:
                begin
                    send_key(line_check_pkg::KEY_BACK);
                    send_key(8'($urandom_range(0, 255)));
                end
            endcase
        end
        drain_pause();

        // Closing stretch at full rate on both sides
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        send_clear();
        random_mixed(25);
        in_valid <= 1'b0;

        // Wait for the last reports, then let the pipeline settle
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        sb.close_out();

        if (sb.fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
